// ===== hw/rtl/olid_pkg.sv =====
package olid_pkg;

    localparam int CAPACITY = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 6;
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam int DATA_W   = 32;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_DELETE = 2'd1;
    localparam logic [1:0] FUNC_READ   = 2'd2;

    typedef struct packed {
        logic [1:0]               func;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic                     ok;
        logic [5:0]               length;
        logic signed [DATA_W-1:0] read_value;
    } out_item_t;

    typedef enum logic [1:0] {
        SHIFT_HOLD,
        SHIFT_INSERT,
        SHIFT_DELETE
    } shift_op_t;

    typedef struct packed {
        shift_op_t                op;
        logic [CMP_W-1:0]         pos;
        logic signed [DATA_W-1:0] value;
    } cell_ctrl_t;

endpackage

// ===== hw/rtl/olid_cell.sv =====
module olid_cell (
    input  logic                                 aclk,
    input  logic [olid_pkg::CMP_W-1:0]           cell_pos,
    input  olid_pkg::cell_ctrl_t                 ctrl,
    input  logic signed [olid_pkg::DATA_W-1:0]   left_data,
    input  logic signed [olid_pkg::DATA_W-1:0]   right_data,
    input  logic [olid_pkg::CMP_W-1:0]           read_pos,
    output logic signed [olid_pkg::DATA_W-1:0]   entry,
    output logic signed [olid_pkg::DATA_W-1:0]   read_data
);

    logic signed [olid_pkg::DATA_W-1:0] entry_reg;
    logic signed [olid_pkg::DATA_W-1:0] entry_next;

    always_comb begin
        entry_next = entry_reg;
        case (ctrl.op)
            olid_pkg::SHIFT_INSERT: begin
                if (cell_pos == ctrl.pos) begin
                    entry_next = ctrl.value;
                end else if (cell_pos > ctrl.pos) begin
                    entry_next = left_data;
                end
            end
            olid_pkg::SHIFT_DELETE: begin
                if (cell_pos >= ctrl.pos) begin
                    entry_next = right_data;
                end
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry     = entry_reg;
    assign read_data = (cell_pos == read_pos) ? entry_reg : '0;

endmodule

// ===== hw/rtl/ordered_list_insert_delete_unit.sv =====
// Ordered list of up to olid_pkg::CAPACITY signed 32-bit words, kept in a row of cells.
// Each input item on s_item carries func (insert, delete, read), a 1-based
// position and a value. Every accepted item gives exactly one result on
// m_item: ok, the list length after the operation, and the word read.
// Insert and delete move every later cell by one place at once,
// since each cell loads from its left or right neighbor in parallel.
// The result is registered at the clock edge that accepts
// the item. Throughput is one item per cycle while m_ready is high.
// s_ready is high when the result register is empty or is being emptied in
// the same cycle; when the receiver stalls, the result holds and s_ready
// drops until it is taken.
// Reset (aresetn low at a clock edge) empties the list and the result
// register. Entry contents are not cleared; only entries below the length
// are ever read.
module ordered_list_insert_delete_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  olid_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output olid_pkg::out_item_t m_item
);

    localparam int CAP = olid_pkg::CAPACITY;

    logic [olid_pkg::CNT_W-1:0] count_reg;
    logic [olid_pkg::CNT_W-1:0] count_next;
    logic                       m_valid_reg;
    logic                       m_valid_next;
    olid_pkg::out_item_t        m_item_reg;
    olid_pkg::out_item_t        m_item_next;

    logic                       accept;
    logic [olid_pkg::CMP_W-1:0] pos_ext;
    logic [olid_pkg::CMP_W-1:0] cnt_ext;
    logic                       pos_nonzero;
    logic                       ins_ok;
    logic                       in_list;
    olid_pkg::cell_ctrl_t       ctrl;
    logic                       op_ok;

    logic signed [olid_pkg::DATA_W-1:0] cell_entry [CAP];
    logic signed [olid_pkg::DATA_W-1:0] cell_rd    [CAP];
    logic signed [olid_pkg::DATA_W-1:0] rd_any;

    assign s_ready     = !m_valid_reg || m_ready;
    assign accept      = s_valid && s_ready;
    assign pos_ext     = olid_pkg::CMP_W'(s_item.position);
    assign cnt_ext     = olid_pkg::CMP_W'(count_reg);
    assign pos_nonzero = (s_item.position != '0);
    assign in_list     = pos_nonzero && (pos_ext <= cnt_ext);
    assign ins_ok      = pos_nonzero && (pos_ext <= cnt_ext + olid_pkg::CMP_W'(1))
                         && (count_reg < olid_pkg::CNT_W'(CAP));

    always_comb begin
        ctrl.op    = olid_pkg::SHIFT_HOLD;
        ctrl.pos   = pos_ext;
        ctrl.value = s_item.value;
        op_ok      = 1'b0;
        count_next = count_reg;
        case (s_item.func)
            olid_pkg::FUNC_INSERT: begin
                op_ok = ins_ok;
                if (accept && ins_ok) begin
                    ctrl.op    = olid_pkg::SHIFT_INSERT;
                    count_next = count_reg + olid_pkg::CNT_W'(1);
                end
            end
            olid_pkg::FUNC_DELETE: begin
                op_ok = in_list;
                if (accept && in_list) begin
                    ctrl.op    = olid_pkg::SHIFT_DELETE;
                    count_next = count_reg - olid_pkg::CNT_W'(1);
                end
            end
            olid_pkg::FUNC_READ: begin
                op_ok = in_list;
            end
            default: begin
                op_ok = 1'b0;
            end
        endcase
    end

    for (genvar i = 0; i < CAP; i++) begin : g_cell
        logic signed [olid_pkg::DATA_W-1:0] left_data;
        logic signed [olid_pkg::DATA_W-1:0] right_data;

        if (i == 0) begin : g_first
            assign left_data = s_item.value;
        end else begin : g_left
            assign left_data = cell_entry[i-1];
        end

        if (i == CAP - 1) begin : g_last
            assign right_data = cell_entry[i];
        end else begin : g_right
            assign right_data = cell_entry[i+1];
        end

        olid_cell u_cell (
            .aclk       (aclk),
            .cell_pos   (olid_pkg::CMP_W'(i + 1)),
            .ctrl       (ctrl),
            .left_data  (left_data),
            .right_data (right_data),
            .read_pos   (pos_ext),
            .entry      (cell_entry[i]),
            .read_data  (cell_rd[i])
        );
    end

    always_comb begin
        rd_any = '0;
        for (int i = 0; i < CAP; i++) begin
            rd_any = rd_any | cell_rd[i];
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        if (accept) begin
            m_valid_next           = 1'b1;
            m_item_next.ok         = op_ok;
            m_item_next.length     = 6'(count_next);
            m_item_next.read_value = (s_item.func == olid_pkg::FUNC_READ && in_list)
                                     ? rd_any : '0;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

// ===== hw/rtl/olid_checker.sv =====
module olid_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input olid_pkg::in_item_t  s_item,
    input logic                m_valid,
    input logic                m_ready,
    input olid_pkg::out_item_t m_item
);

    // A stalled result must hold its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted item gave no result");

    a_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_item.position == '0 |=> m_valid && !m_item.ok)
        else $error("position zero was not rejected");

    a_rd_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.ok |-> m_item.read_value == '0)
        else $error("failed item carries nonzero read value");

    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result register");

endmodule

bind ordered_list_insert_delete_unit olid_checker u_olid_checker (.*);

// ===== dv/ordered_list_insert_delete_unit_test.sv =====
module ordered_list_insert_delete_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam logic signed [olid_pkg::DATA_W-1:0] DATA_MIN = 32'sh8000_0000;
    localparam logic signed [olid_pkg::DATA_W-1:0] DATA_MAX = 32'sh7fff_ffff;
    localparam int NUM_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int DRAIN_CYCLES = 4;

    typedef struct packed {
        olid_pkg::in_item_t  item;
        logic                typed;
        olid_pkg::out_item_t want;
    } script_row_t;

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    olid_pkg::in_item_t  s_item = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    olid_pkg::out_item_t m_item;

    logic signed [olid_pkg::DATA_W-1:0] list_words [olid_pkg::CAPACITY];
    int list_len = 0;
    olid_pkg::out_item_t pending_results [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_request = 0;
    int hold_left = 0;
    int error_count = 0;
    int results_seen = 0;
    int inserts_done = 0;
    int deletes_done = 0;
    int reads_done = 0;
    int rejected_ops = 0;
    int full_rejects = 0;
    int peak_len = 0;

    int phase_idle   [NUM_PHASES] = '{0, 66, 0, 38, 0, 0, 38, 66};
    int phase_stall  [NUM_PHASES] = '{0, 0, 66, 38, 0, 0, 38, 0};
    int phase_insert [NUM_PHASES] = '{70, 45, 25, 70, 45, 75, 25, 45};
    int phase_delete [NUM_PHASES] = '{15, 35, 60, 15, 35, 10, 60, 35};

    script_row_t directed_script [22] = '{
        '{'{olid_pkg::FUNC_READ,   6'd1,  32'sd0},   1'b1, '{1'b0, 6'd0, 32'sd0}},
        '{'{olid_pkg::FUNC_DELETE, 6'd1,  32'sd0},   1'b1, '{1'b0, 6'd0, 32'sd0}},
        '{'{olid_pkg::FUNC_INSERT, 6'd0,  32'sd5},   1'b1, '{1'b0, 6'd0, 32'sd0}},
        '{'{olid_pkg::FUNC_INSERT, 6'd2,  32'sd5},   1'b1, '{1'b0, 6'd0, 32'sd0}},
        '{'{olid_pkg::FUNC_INSERT, 6'd1,  DATA_MIN}, 1'b1, '{1'b1, 6'd1, 32'sd0}},
        '{'{olid_pkg::FUNC_INSERT, 6'd2,  DATA_MAX}, 1'b1, '{1'b1, 6'd2, 32'sd0}},
        '{'{FUNC_UNUSED,           6'd1,  32'sd0},   1'b1, '{1'b0, 6'd2, 32'sd0}},
        '{'{olid_pkg::FUNC_READ,   6'd1,  32'sd0},   1'b1, '{1'b1, 6'd2, DATA_MIN}},
        '{'{olid_pkg::FUNC_READ,   6'd2,  32'sd0},   1'b1, '{1'b1, 6'd2, DATA_MAX}},
        '{'{olid_pkg::FUNC_READ,   6'd3,  32'sd0},   1'b1, '{1'b0, 6'd2, 32'sd0}},
        '{'{olid_pkg::FUNC_READ,   6'd0,  32'sd0},   1'b1, '{1'b0, 6'd2, 32'sd0}},
        '{'{olid_pkg::FUNC_READ,   6'd63, 32'sd0},   1'b1, '{1'b0, 6'd2, 32'sd0}},
        '{'{olid_pkg::FUNC_INSERT, 6'd63, 32'sd7},   1'b1, '{1'b0, 6'd2, 32'sd0}},
        '{'{olid_pkg::FUNC_INSERT, 6'd1,  -32'sd1},  1'b0, '0},
        '{'{olid_pkg::FUNC_INSERT, 6'd3,  32'sh1234_5678}, 1'b0, '0},
        '{'{olid_pkg::FUNC_DELETE, 6'd0,  32'sd0},   1'b1, '{1'b0, 6'd4, 32'sd0}},
        '{'{olid_pkg::FUNC_DELETE, 6'd5,  32'sd0},   1'b1, '{1'b0, 6'd4, 32'sd0}},
        '{'{olid_pkg::FUNC_DELETE, 6'd2,  32'sd0},   1'b0, '0},
        '{'{olid_pkg::FUNC_DELETE, 6'd3,  32'sd0},   1'b0, '0},
        '{'{olid_pkg::FUNC_READ,   6'd1,  32'sd0},   1'b0, '0},
        '{'{olid_pkg::FUNC_READ,   6'd2,  32'sd0},   1'b0, '0},
        '{'{FUNC_UNUSED,           6'd63, DATA_MAX}, 1'b1, '{1'b0, 6'd2, 32'sd0}}
    };

    ordered_list_insert_delete_unit u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic olid_pkg::out_item_t apply_list_op(input olid_pkg::in_item_t op);
        olid_pkg::out_item_t res;
        int pos;
        res = '0;
        pos = op.position;
        case (op.func)
            olid_pkg::FUNC_INSERT: begin
                if (pos >= 1 && pos <= list_len + 1 && list_len < olid_pkg::CAPACITY) begin
                    for (int k = list_len; k >= pos; k--) begin
                        list_words[k] = list_words[k-1];
                    end
                    list_words[pos-1] = op.value;
                    list_len++;
                    res.ok = 1'b1;
                    inserts_done++;
                end else if (pos >= 1 && pos <= list_len + 1) begin
                    full_rejects++;
                end
            end
            olid_pkg::FUNC_DELETE: begin
                if (pos >= 1 && pos <= list_len) begin
                    for (int k = pos; k < list_len; k++) begin
                        list_words[k-1] = list_words[k];
                    end
                    list_len--;
                    res.ok = 1'b1;
                    deletes_done++;
                end
            end
            olid_pkg::FUNC_READ: begin
                if (pos >= 1 && pos <= list_len) begin
                    res.read_value = list_words[pos-1];
                    res.ok = 1'b1;
                    reads_done++;
                end
            end
            default: begin
            end
        endcase
        if (!res.ok) begin
            rejected_ops++;
        end
        if (list_len > peak_len) begin
            peak_len = list_len;
        end
        res.length = list_len[5:0];
        return res;
    endfunction

    function automatic olid_pkg::in_item_t pick_list_op(input int insert_pct,
                                                        input int delete_pct);
        olid_pkg::in_item_t op;
        int roll;
        int legal_hi;
        int sel;
        roll = $urandom_range(99);
        if (roll < insert_pct) begin
            op.func = olid_pkg::FUNC_INSERT;
        end else if (roll < insert_pct + delete_pct) begin
            op.func = olid_pkg::FUNC_DELETE;
        end else if (roll < 97) begin
            op.func = olid_pkg::FUNC_READ;
        end else begin
            op.func = FUNC_UNUSED;
        end
        legal_hi = (op.func == olid_pkg::FUNC_INSERT) ? list_len + 1 : list_len;
        roll = $urandom_range(99);
        if (roll < 85 && legal_hi >= 1) begin
            sel = $urandom_range(legal_hi, 1);
        end else if (roll < 93) begin
            sel = $urandom_range(1) ? 0 : legal_hi + 1;
        end else begin
            sel = $urandom_range(63);
        end
        op.position = sel[olid_pkg::POS_W-1:0];
        case ($urandom_range(15))
            0: op.value = DATA_MIN;
            1: op.value = DATA_MAX;
            2: op.value = '0;
            3: op.value = -32'sd1;
            default: op.value = $urandom;
        endcase
        return op;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH result %0d %s: got %0d, expected %0d", results_seen, what, got, want);
        error_count++;
    endtask

    task automatic offer_item(input olid_pkg::in_item_t op, input logic typed,
                              input olid_pkg::out_item_t typed_res);
        olid_pkg::out_item_t predicted;
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= op;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        predicted = apply_list_op(op);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        @(posedge aclk);
    endtask

    always @(negedge aclk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        olid_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, length", m_item.length, 0);
            end else begin
                want = pending_results.pop_front();
                if (m_item.ok !== want.ok) begin
                    report_mismatch("ok", m_item.ok, want.ok);
                end
                if (m_item.length !== want.length) begin
                    report_mismatch("length", m_item.length, want.length);
                end
                if (m_item.read_value !== want.read_value) begin
                    report_mismatch("read_value", m_item.read_value, want.read_value);
                end
            end
        end
    end

    initial begin
        foreach (list_words[i]) begin
            list_words[i] = '0;
        end
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_script[i]) begin
            offer_item(directed_script[i].item, directed_script[i].typed,
                       directed_script[i].want);
        end
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++) begin
            send_idle_pct = phase_idle[p];
            recv_stall_pct = phase_stall[p];
            // Phase four starts with a long receiver hold-off so the input backs up.
            if (p == 4) begin
                hold_request = HOLD_OFF_CYCLES;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                offer_item(pick_list_op(phase_insert[p], phase_delete[p]), 1'b0, '0);
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0) begin
            report_mismatch("results never arrived", 0, pending_results.size());
        end

        $display("Ran %0d list operations: %0d inserts, %0d deletes, %0d reads done.",
                 results_seen, inserts_done, deletes_done, reads_done);
        $display("%0d operations rejected, %0d of them inserts into a full list; peak length %0d.",
                 rejected_ops, full_rejects, peak_len);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
